>>> sv/aiws_pkg.sv
// Shared types and constants for the affine warp sampler.
// No dependencies; the top level, front end and back end import this package.
package aiws_pkg;

  // Field widths
  localparam int COEF_W    = 32;
  localparam int COORD_W   = 10;
  localparam int SIZE_W    = 10;
  localparam int PIX_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Fixed-point datapath widths
  localparam int FRAC_W = 16;
  localparam int PROD_W = COEF_W + COORD_W + 1;   // coef * unsigned coordinate
  localparam int SUM_W  = PROD_W + 2;             // two products plus a coefficient
  localparam int MAG_W  = SUM_W - FRAC_W;         // rounded magnitude
  localparam int LIM_W  = COORD_W + 1;            // coordinate or limit up to 1024
  localparam int LIN_W  = 2 * COORD_W + 1;        // linear store address before trim

  localparam logic [SUM_W-1:0] ROUND_HALF     = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [SUM_W-1:0] ROUND_HALF_NEG = ROUND_HALF + SUM_W'(1);

  // Reset values
  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << FRAC_W;
  localparam logic [COEF_W-1:0] COEF_ZERO  = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_COEF_XT    = 3'd2,
    REG_COEF_YX    = 3'd3,
    REG_COEF_YY    = 3'd4,
    REG_COEF_YT    = 3'd5,
    REG_SRC_WIDTH  = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  // Classified operation handed from the front to the back
  typedef struct packed {
    logic sample;   // produces a result
    logic store;    // load with an in-range address
    logic hit;      // sample maps inside the source
  } op_t;

endpackage

>>> sv/affine_image_warp_sampler.sv
// Top level of the affine warp sampler: front end, queue and back end.
// Depends on aiws_pkg, aiws_front, aiws_fifo and aiws_back.
//
// Usage:
//  - Input channel (push/full): one beat per cycle while full is low. A beat
//    with action_i = load writes pixel_in_i at (col_i, row_i) and returns
//    nothing; action_i = sample maps (col_i, row_i) through the inverse
//    affine matrix and returns one result.
//  - Result channel (empty/pop): the oldest result sits on pixel_out_o and
//    inside_res_o while empty is low; pop takes it.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i.
//    Write only while no sample is in flight.
//  - Throughput: one beat per cycle while full is low, loads and samples mixed
//    in any order. A sample passes the product stage and two more mapping
//    stages, the queue, the registered frame store read and the result queue.
//  - Reset sets the identity matrix and a 512x512 source; the frame store is
//    not cleared and must be loaded before it is sampled.
//  - When pop stalls, the 4-entry result queue and the 4-entry internal
//    queue fill, then full rises; nothing is lost.
module affine_image_warp_sampler
  import aiws_pkg::*;
#(
  parameter int MAX_COLS     = 512,
  parameter int MAX_ROWS     = 512,
  parameter int CHANNELS     = 4,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 push,
  output logic                 full,
  input  logic                 action_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic                 inside_res_o,
  // config port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int PIX_BITS  = CHANNELS * CHANNEL_BITS;
  localparam int DEPTH     = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;
  localparam int Q_W       = $bits(op_t) + ADDR_W + PIX_BITS;

  logic                q_push, q_full, q_pop, q_empty;
  op_t                 f_op, b_op;
  logic [ADDR_W-1:0]   f_addr, b_addr;
  logic [PIX_BITS-1:0] f_pix, b_pix;
  logic [Q_W-1:0]      q_wdata, q_rdata;

  // Mapping and classification
  aiws_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .PIX_BITS (PIX_BITS),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .action_i   (action_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .pixel_in_i (pixel_in_i[PIX_BITS-1:0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_push_o   (q_push),
    .q_full_i   (q_full),
    .q_op_o     (f_op),
    .q_addr_o   (f_addr),
    .q_pix_o    (f_pix)
  );

  // Decoupling queue between front and back
  assign q_wdata = {f_op, f_addr, f_pix};
  assign {b_op, b_addr, b_pix} = q_rdata;

  aiws_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .count_o ()
  );

  // Frame store and results
  aiws_back #(
    .PIX_BITS  (PIX_BITS),
    .ADDR_W    (ADDR_W),
    .DEPTH     (DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_op_i       (b_op),
    .q_addr_i     (b_addr),
    .q_pix_i      (b_pix),
    .empty_o      (empty),
    .pop_i        (pop),
    .pixel_out_o  (pixel_out_o),
    .inside_res_o (inside_res_o)
  );

endmodule

>>> sv/aiws_fifo.sv
// Small synchronous FIFO with occupancy count.
// Used for the front-to-back queue and the result queue; depends on nothing.
module aiws_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               wdata_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               rdata_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Users must respect full and empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("fifo push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("fifo pop while empty");

endmodule

>>> sv/aiws_front.sv
// Front end: config registers, affine mapping pipeline and item classification.
// Depends on aiws_pkg; feeds the front-to-back queue.
module aiws_front
  import aiws_pkg::*;
#(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 512,
  parameter int PIX_BITS = 32,
  parameter int ADDR_W   = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input beats
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 action_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [PIX_BITS-1:0]  pixel_in_i,
  // config writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // queue side
  output logic                 q_push_o,
  input  logic                 q_full_i,
  output op_t                  q_op_o,
  output logic [ADDR_W-1:0]    q_addr_o,
  output logic [PIX_BITS-1:0]  q_pix_o
);

  localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(MAX_COLS);
  localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(MAX_ROWS);

  // Q29.16 sum to integer magnitude, half away from zero
  function automatic logic [MAG_W-1:0] round_mag(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] adj;
    adj = s[SUM_W-1] ? (~s + ROUND_HALF_NEG) : (s + ROUND_HALF);
    return adj[SUM_W-1:FRAC_W];
  endfunction

  // ---------------- config registers ----------------
  logic signed [COEF_W-1:0] coef_xx_q, coef_xy_q, coef_xt_q;
  logic signed [COEF_W-1:0] coef_yx_q, coef_yy_q, coef_yt_q;
  logic [SIZE_W-1:0]        src_width_q, src_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q    <= COEF_ONE;
      coef_xy_q    <= COEF_ZERO;
      coef_xt_q    <= COEF_ZERO;
      coef_yx_q    <= COEF_ZERO;
      coef_yy_q    <= COEF_ONE;
      coef_yt_q    <= COEF_ZERO;
      src_width_q  <= SIZE_RESET;
      src_height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_XX:    coef_xx_q    <= cfg_data_i;
        REG_COEF_XY:    coef_xy_q    <= cfg_data_i;
        REG_COEF_XT:    coef_xt_q    <= cfg_data_i;
        REG_COEF_YX:    coef_yx_q    <= cfg_data_i;
        REG_COEF_YY:    coef_yy_q    <= cfg_data_i;
        REG_COEF_YT:    coef_yt_q    <= cfg_data_i;
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // All stages move together; only a full queue with a waiting item stalls.
  logic en, accept;
  logic p_v_q, s_v_q, r_v_q;

  assign en     = !(r_v_q && q_full_i);
  assign accept = push_i && en;
  assign full_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      s_v_q <= 1'b0;
      r_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= accept;
      s_v_q <= p_v_q;
      r_v_q <= s_v_q;
    end
  end

  // ---------------- datapath ----------------
  action_e                 p_act_q, s_act_q, r_act_q;
  logic [COORD_W-1:0]      p_col_q, s_col_q, r_col_q;
  logic [COORD_W-1:0]      p_row_q, s_row_q, r_row_q;
  logic [PIX_BITS-1:0]     p_pix_q, s_pix_q, r_pix_q;
  logic signed [PROD_W-1:0] p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [COEF_W-1:0] p_xt_q, p_yt_q;
  logic [SUM_W-1:0]        s_u_q, s_v_q2;
  logic [MAG_W-1:0]        r_mag_u_q, r_mag_v_q;
  logic                    r_neg_u_q, r_neg_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products
      p_act_q <= action_e'(action_i);
      p_col_q <= col_i;
      p_row_q <= row_i;
      p_pix_q <= pixel_in_i;
      p_xx_q  <= coef_xx_q * $signed({1'b0, col_i});
      p_xy_q  <= coef_xy_q * $signed({1'b0, row_i});
      p_yx_q  <= coef_yx_q * $signed({1'b0, col_i});
      p_yy_q  <= coef_yy_q * $signed({1'b0, row_i});
      p_xt_q  <= coef_xt_q;
      p_yt_q  <= coef_yt_q;
      // sums
      s_act_q <= p_act_q;
      s_col_q <= p_col_q;
      s_row_q <= p_row_q;
      s_pix_q <= p_pix_q;
      s_u_q   <= {{(SUM_W-PROD_W){p_xx_q[PROD_W-1]}}, p_xx_q}
               + {{(SUM_W-PROD_W){p_xy_q[PROD_W-1]}}, p_xy_q}
               + {{(SUM_W-COEF_W){p_xt_q[COEF_W-1]}}, p_xt_q};
      s_v_q2  <= {{(SUM_W-PROD_W){p_yx_q[PROD_W-1]}}, p_yx_q}
               + {{(SUM_W-PROD_W){p_yy_q[PROD_W-1]}}, p_yy_q}
               + {{(SUM_W-COEF_W){p_yt_q[COEF_W-1]}}, p_yt_q};
      // rounding
      r_act_q   <= s_act_q;
      r_col_q   <= s_col_q;
      r_row_q   <= s_row_q;
      r_pix_q   <= s_pix_q;
      r_mag_u_q <= round_mag(s_u_q);
      r_mag_v_q <= round_mag(s_v_q2);
      r_neg_u_q <= s_u_q[SUM_W-1];
      r_neg_v_q <= s_v_q2[SUM_W-1];
    end
  end

  // ---------------- classification ----------------
  // A negative point is inside only when it rounds to zero.
  logic [LIM_W-1:0]   w_eff, h_eff;
  logic               is_sample, inside_u, inside_v, store_ok;
  logic [COORD_W-1:0] x_sel, y_sel;
  logic [LIN_W-1:0]   lin;

  always_comb begin
    w_eff = ({1'b0, src_width_q} > COLS_LIM) ? COLS_LIM : {1'b0, src_width_q};
    h_eff = ({1'b0, src_height_q} > ROWS_LIM) ? ROWS_LIM : {1'b0, src_height_q};
    is_sample = (r_act_q == ACT_SAMPLE);
    inside_u  = (!r_neg_u_q || (r_mag_u_q == '0)) && (r_mag_u_q < MAG_W'(w_eff));
    inside_v  = (!r_neg_v_q || (r_mag_v_q == '0)) && (r_mag_v_q < MAG_W'(h_eff));
    store_ok  = !is_sample && ({1'b0, r_col_q} < COLS_LIM) && ({1'b0, r_row_q} < ROWS_LIM);
    x_sel     = is_sample ? r_mag_u_q[COORD_W-1:0] : r_col_q;
    y_sel     = is_sample ? r_mag_v_q[COORD_W-1:0] : r_row_q;
    lin       = LIN_W'(y_sel) * LIN_W'(MAX_COLS) + LIN_W'(x_sel);
  end

  assign q_push_o = r_v_q && !q_full_i;
  assign q_op_o   = '{sample: is_sample, store: store_ok, hit: inside_u && inside_v};
  assign q_addr_o = lin[ADDR_W-1:0];
  assign q_pix_o  = r_pix_q;

  // A stall can only come from an item waiting at the last stage
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (r_v_q && q_full_i))
    else $error("front stalled without a waiting item");

endmodule

>>> sv/aiws_back.sv
// Back end: frame store access and result queue.
// Depends on aiws_pkg and aiws_fifo; drains the front-to-back queue.
module aiws_back
  import aiws_pkg::*;
#(
  parameter int PIX_BITS  = 32,
  parameter int ADDR_W    = 18,
  parameter int DEPTH     = 262144,
  parameter int OUT_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // queue side
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  op_t                 q_op_i,
  input  logic [ADDR_W-1:0]   q_addr_i,
  input  logic [PIX_BITS-1:0] q_pix_i,
  // result beats
  output logic                empty_o,
  input  logic                pop_i,
  output logic [PIX_W-1:0]    pixel_out_o,
  output logic                inside_res_o
);

  localparam int OCC_W = $clog2(OUT_DEPTH + 1);

  logic [PIX_BITS-1:0] mem [DEPTH];
  logic [PIX_BITS-1:0] rd_q;
  logic                pend_q, ins_q;
  logic [OCC_W-1:0]    out_count;
  logic                out_full, out_empty;
  logic                credit_ok;
  logic [PIX_W:0]      out_wdata, out_rdata;

  // A sample goes ahead only if its result has a guaranteed slot
  assign credit_ok = ({1'b0, out_count} + (OCC_W+1)'(pend_q)) < (OCC_W+1)'(OUT_DEPTH);
  assign q_pop_o   = !q_empty_i && (!q_op_i.sample || credit_ok);

  // Frame store: in-range loads write, inside samples read
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.store) begin
      mem[q_addr_i] <= q_pix_i;
    end
    if (q_pop_o && q_op_i.sample && q_op_i.hit) begin
      rd_q <= mem[q_addr_i];
    end
    if (q_pop_o) begin
      ins_q <= q_op_i.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= q_pop_o && q_op_i.sample;
    end
  end

  // Result queue
  assign out_wdata = {ins_q, ins_q ? PIX_W'(rd_q) : PIX_W'(0)};

  aiws_fifo #(
    .WIDTH (PIX_W + 1),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pend_q),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i && !out_empty),
    .rdata_o (out_rdata),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign empty_o      = out_empty;
  assign pixel_out_o  = out_rdata[PIX_W-1:0];
  assign inside_res_o = out_rdata[PIX_W];

  // Credit check must keep a slot for every read in flight
  a_credit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_full)
    else $error("result arrived with result queue full");

endmodule
